[src/quickprop_weight_update_defines.svh]
// Assertion macros used by the top-level RTL file of the weight update block.
`ifndef QUICKPROP_WEIGHT_UPDATE_DEFINES_SVH
`define QUICKPROP_WEIGHT_UPDATE_DEFINES_SVH
`ifndef ASSERT_OFF
`define QPWU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define QPWU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define QPWU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define QPWU_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[src/qpwu_pkg.sv]
`default_nettype none
package qpwu_pkg;

    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 31;
    // Quotient bits kept by the divider; larger quotients saturate the change anyway.
    localparam int QBITS  = 34;

    localparam logic [23:0] EPS          = 24'd15099494;
    localparam logic [31:0] TINY         = 32'd1677;
    localparam logic [31:0] ONE          = 32'd16777216;
    localparam logic [62:0] ROUND        = 63'd8388608;
    localparam logic [30:0] MAXCHG_RESET = 31'd29360128;

    typedef struct packed {
        logic               store;
        logic [11:0]        idx;
        logic [31:0]        grad;
        logic [31:0]        wval;
        logic signed [39:0] base;
        logic               need_q;
        logic               q_neg;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [32:0] dvsr;
        logic [31:0] rem;
        logic [33:0] num_lo;
        logic [33:0] quo;
        logic        q_ovf;
        logic        q_zero;
    } t_div;

    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] r;
        if (v > 41'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -41'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/qpwu_store.sv]
`default_nettype none
module qpwu_store #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_rd_en,
    input  wire  [11:0] i_rd_idx,
    output logic        o_rd_in_range,
    output logic [63:0] o_rd_data,
    input  wire         i_wr_en,
    input  wire  [11:0] i_wr_idx,
    input  wire  [63:0] i_wr_data,
    output logic        o_busy
);

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_WEIGHTS - 1);

    logic [63:0]   mem [NUM_WEIGHTS];
    logic [63:0]   r_rd_data;
    logic [AW-1:0] r_clr_cnt;
    logic          r_clearing;
    logic [31:0]   rd_wide;
    logic [31:0]   wr_wide;

    assign rd_wide       = 32'(i_rd_idx);
    assign wr_wide       = 32'(i_wr_idx);
    assign o_rd_in_range = rd_wide < 32'(NUM_WEIGHTS);
    assign o_rd_data     = r_rd_data;
    assign o_busy        = r_clearing;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == LAST) begin
                r_clearing <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_wr_en) begin
            mem[wr_wide[AW-1:0]] <= i_wr_data;
        end
        if (i_rd_en && o_rd_in_range) begin
            r_rd_data <= mem[rd_wide[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

[src/qpwu_div.sv]
`default_nettype none
module qpwu_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire qpwu_pkg::t_side i_side,
    input  wire  [62:0]         i_num,
    input  wire  [32:0]         i_dvsr,
    input  wire  [11:0]         i_probe_idx,
    output logic                o_hit,
    output logic                o_valid,
    output qpwu_pkg::t_div      o_out
);

    localparam int N_ST = qpwu_pkg::QBITS + 1;

    logic           r_vld [N_ST];
    qpwu_pkg::t_div r_st  [N_ST];
    qpwu_pkg::t_div init;

    // One restoring step: bring in the next numerator bit, subtract when it fits.
    function automatic qpwu_pkg::t_div step(input qpwu_pkg::t_div s);
        qpwu_pkg::t_div r;
        logic [32:0]    t;
        logic           qb;
        r  = s;
        t  = {s.rem, s.num_lo[33]};
        qb = (t >= s.dvsr);
        if (qb) begin
            r.rem = 32'(t - s.dvsr);
        end else begin
            r.rem = t[31:0];
        end
        r.num_lo = {s.num_lo[32:0], 1'b0};
        r.quo    = {s.quo[32:0], qb};
        return r;
    endfunction

    always_comb begin
        init.side   = i_side;
        init.dvsr   = i_dvsr;
        init.rem    = 32'(i_num[62:34]);
        init.num_lo = i_num[33:0];
        init.quo    = '0;
        init.q_zero = (i_dvsr == '0);
        init.q_ovf  = ({4'b0, i_num[62:34]} >= i_dvsr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < N_ST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= init;
            for (int k = 1; k < N_ST; k++) begin
                r_st[k] <= step(r_st[k-1]);
            end
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < N_ST; k++) begin
            o_hit = o_hit | (r_vld[k] & r_st[k].side.store
                             & (r_st[k].side.idx == i_probe_idx));
        end
    end

    assign o_valid = r_vld[N_ST-1];
    assign o_out   = r_st[N_ST-1];

endmodule
`default_nettype wire

[src/quickprop_weight_update.sv]
// Quickprop update for one weight per item. An item enters in every cycle unless its weight
// index is still being updated by an earlier item, in which case it waits until that item has
// written its gradient and change back to the state memory (a wait that grows while the
// output is stalled), or unless the output skid entry is full. An accepted item passes the
// memory read, product, divider, change and output registers in that order; the 34-step
// pipelined divider forms the quadratic step. After reset the state memory is cleared one
// entry a cycle, so no item is accepted until that sweep ends; the max_change register may
// be written at any idle time, including during that sweep.
`default_nettype none
`include "quickprop_weight_update_defines.svh"
module quickprop_weight_update #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [30:0] i_cfg_wr_data,   // max_change
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [79:0] i_s_axis_tdata,  // weight_index[11:0], gradient[43:12], weight_value[75:44]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata   // new_weight[31:0], weight_change[63:32]
);

    logic [30:0] r_max_change;

    logic        en;
    logic        s_accept;
    logic        hazard;
    logic        st_busy;
    logic        in_range;
    logic [63:0] rd_data;
    logic [11:0] in_idx;

    // stage 1: memory data arrives
    logic        r_s1_v;
    logic        r_s1_store;
    logic [11:0] r_s1_idx;
    logic [31:0] r_s1_g;
    logic [31:0] r_s1_w;

    // stage 2: products
    logic        r_s2_v;
    logic        r_s2_store;
    logic [11:0] r_s2_idx;
    logic [31:0] r_s2_g;
    logic [31:0] r_s2_w;
    logic [63:0] r_s2_lhs;
    logic [62:0] r_s2_rhs;
    logic [55:0] r_s2_eps;
    logic [62:0] r_s2_mg;
    logic [63:0] r_s2_num;
    logic [32:0] r_s2_d;
    logic        r_s2_tiny;
    logic        r_s2_same;
    logic        r_s2_x_neg;
    logic        r_s2_g_neg;
    logic        r_s2_num_neg;

    // stage 3: change, written back on leaving
    logic        r_s3_v;
    logic        r_s3_store;
    logic [11:0] r_s3_idx;
    logic [31:0] r_s3_g;
    logic [31:0] r_s3_w;
    logic [31:0] r_s3_c;

    logic        r_out_v;
    logic [63:0] r_out_data;
    logic        r_skid_v;
    logic [63:0] r_skid_data;

    logic [31:0] pg, pc, mag_g, mag_pg, mag_pc, mag_x, x, m_plus;
    logic [63:0] eps_sum;
    logic [62:0] mg_sum;
    logic [31:0] eps_r;
    logic [38:0] mg_r;
    logic        use_max;
    logic signed [39:0] eps_term, mg_term;
    logic [32:0] d_mag;
    qpwu_pkg::t_side side_in;
    logic        div_hit;
    logic        div_v;
    qpwu_pkg::t_div div_out;
    logic [34:0] qv;
    logic [40:0] qext, qterm;
    logic signed [40:0] c_sum, nw_sum;
    logic [31:0] nw;
    logic [63:0] result;
    logic        out_take;

    assign in_idx = i_s_axis_tdata[11:0];
    assign en     = !r_skid_v;
    assign hazard = div_hit
                    | (r_s1_v & r_s1_store & (r_s1_idx == in_idx))
                    | (r_s2_v & r_s2_store & (r_s2_idx == in_idx))
                    | (r_s3_v & r_s3_store & (r_s3_idx == in_idx));
    assign o_s_axis_tready = en & !st_busy & !hazard;
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_change <= qpwu_pkg::MAXCHG_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_change <= i_cfg_wr_data;
        end
    end

    qpwu_store #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (s_accept),
        .i_rd_idx      (in_idx),
        .o_rd_in_range (in_range),
        .o_rd_data     (rd_data),
        .i_wr_en       (en & r_s3_v & r_s3_store),
        .i_wr_idx      (r_s3_idx),
        .i_wr_data     ({r_s3_g, r_s3_c}),
        .o_busy        (st_busy)
    );

    // Stage 1 arithmetic: magnitudes and all products.
    always_comb begin
        pg     = r_s1_store ? rd_data[63:32] : '0;
        pc     = r_s1_store ? rd_data[31:0]  : '0;
        mag_g  = r_s1_g[31] ? 32'(-r_s1_g) : r_s1_g;
        mag_pg = pg[31] ? 32'(-pg) : pg;
        mag_pc = pc[31] ? 32'(-pc) : pc;
        x      = (mag_g <= qpwu_pkg::TINY) ? pg : r_s1_g;
        mag_x  = x[31] ? 32'(-x) : x;
        m_plus = 32'(r_max_change) + qpwu_pkg::ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= s_accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (s_accept) begin
                r_s1_store <= in_range;
                r_s1_idx   <= in_idx;
                r_s1_g     <= i_s_axis_tdata[43:12];
                r_s1_w     <= i_s_axis_tdata[75:44];
            end
            r_s2_store   <= r_s1_store;
            r_s2_idx     <= r_s1_idx;
            r_s2_g       <= r_s1_g;
            r_s2_w       <= r_s1_w;
            r_s2_lhs     <= 64'(mag_g) * 64'(m_plus);
            r_s2_rhs     <= 63'(r_max_change) * 63'(mag_pg);
            r_s2_eps     <= 56'(mag_x) * 56'(qpwu_pkg::EPS);
            r_s2_mg      <= 63'(r_max_change) * 63'(mag_g);
            r_s2_num     <= 64'(mag_g) * 64'(mag_pc);
            r_s2_d       <= {pg[31], pg} - {r_s1_g[31], r_s1_g};
            r_s2_tiny    <= (mag_g <= qpwu_pkg::TINY);
            r_s2_same    <= (r_s1_g[31] == pg[31]);
            r_s2_x_neg   <= x[31];
            r_s2_g_neg   <= r_s1_g[31];
            r_s2_num_neg <= r_s1_g[31] ^ pc[31];
        end
    end

    // Stage 2 arithmetic: rounding, branch choice and the non-quotient part of the change.
    always_comb begin
        eps_sum = 64'(r_s2_eps) + 64'(qpwu_pkg::ROUND);
        mg_sum  = r_s2_mg + qpwu_pkg::ROUND;
        eps_r   = eps_sum[55:24];
        mg_r    = mg_sum[62:24];
        use_max = r_s2_lhs > {1'b0, r_s2_rhs};
        if (r_s2_tiny || r_s2_same) begin
            eps_term = r_s2_x_neg ? -$signed({8'b0, eps_r}) : $signed({8'b0, eps_r});
        end else begin
            eps_term = '0;
        end
        if (!r_s2_tiny && r_s2_same && use_max) begin
            mg_term = r_s2_g_neg ? -$signed({1'b0, mg_r}) : $signed({1'b0, mg_r});
        end else begin
            mg_term = '0;
        end
        d_mag          = r_s2_d[32] ? 33'(-r_s2_d) : r_s2_d;
        side_in.store  = r_s2_store;
        side_in.idx    = r_s2_idx;
        side_in.grad   = r_s2_g;
        side_in.wval   = r_s2_w;
        side_in.base   = eps_term + mg_term;
        side_in.need_q = !r_s2_tiny && !(r_s2_same && use_max);
        side_in.q_neg  = r_s2_num_neg ^ r_s2_d[32];
    end

    qpwu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s2_v),
        .i_side      (side_in),
        .i_num       (r_s2_num[62:0]),
        .i_dvsr      (d_mag),
        .i_probe_idx (in_idx),
        .o_hit       (div_hit),
        .o_valid     (div_v),
        .o_out       (div_out)
    );

    // Quotient is forced to zero for a zero divisor and clamped when it exceeds its bits.
    always_comb begin
        if (div_out.q_zero) begin
            qv = '0;
        end else if (div_out.q_ovf) begin
            qv = 35'h4_0000_0000;
        end else begin
            qv = {1'b0, div_out.quo};
        end
        qext = {6'b0, qv};
        if (div_out.side.need_q) begin
            qterm = div_out.side.q_neg ? 41'(-qext) : qext;
        end else begin
            qterm = '0;
        end
        c_sum  = $signed({div_out.side.base[39], div_out.side.base}) + $signed(qterm);
        nw_sum = $signed({{9{r_s3_w[31]}}, r_s3_w}) + $signed({{9{r_s3_c[31]}}, r_s3_c});
        nw     = qpwu_pkg::sat32(nw_sum);
        result = {r_s3_c, nw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_store <= div_out.side.store;
            r_s3_idx   <= div_out.side.idx;
            r_s3_g     <= div_out.side.grad;
            r_s3_w     <= div_out.side.wval;
            r_s3_c     <= qpwu_pkg::sat32(c_sum);
        end
    end

    // Output register with one skid entry; the pipeline halts only while the skid is full.
    assign out_take = r_out_v & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || out_take) begin
            r_out_v <= r_s3_v;
        end else if (r_s3_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_v || out_take) begin
            r_out_data <= result;
        end else begin
            r_skid_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

    `QPWU_ASSERT_IMPLY(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid holds an item while the output is empty")
    `QPWU_ASSERT_NEVER(a_no_accept_clearing, i_clk, i_rst_n, s_accept && st_busy, "item accepted during the clearing sweep")
    `QPWU_ASSERT_IMPLY(a_skid_fill_cause, i_clk, i_rst_n, $rose(r_skid_v), $past(r_out_v) && !$past(i_m_axis_tready), "skid filled without a stalled output")

endmodule
`default_nettype wire
